// File: hdl/assert_macros.svh
// Assertion macros for the integrate-and-fire neuron array.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on the rising clock edge, disabled while the active-low reset is asserted.
`define IFN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on the rising clock edge, also active during reset.
`define IFN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/ifn_pkg.sv
// Package for the integrate-and-fire neuron array: sizes, codes and shared types.
// No dependencies.
`default_nettype none

package ifn_pkg;

    localparam int NEURONS = 32;
    localparam int IDX_W   = 5;
    localparam int FRAC_W  = 24;
    localparam int THR_W   = 31;
    localparam int TS_W    = 25;
    localparam int CFG_W   = 31;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(1677722);
    localparam logic [TS_W-1:0]  TIMESTEP_RESET  = TS_W'(1678);

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_TIMESTEP  = 1'b1;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_SET_ONE = 3'd1,
        MODE_SET_ALL = 3'd2,
        MODE_LOAD    = 3'd3,
        MODE_READ    = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_MUL,
        S_MEM,
        S_FIRE,
        S_READ
    } t_state;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_MULSH,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic [2:0]        mode;
        logic [IDX_W-1:0]  neuron;
        logic signed [31:0] potential;
        logic signed [31:0] current;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] neuron_index;
        logic             spiked;
        logic [31:0]      count;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [TS_W-1:0]  timestep;
    } t_cfg;

endpackage

`default_nettype wire

// File: hdl/ifn_alu.sv
// Shared arithmetic unit: saturating add, saturating subtract, and
// timestep multiply with floor shift and saturation. Uses ifn_pkg.
`default_nettype none

module ifn_alu (
    input  wire ifn_pkg::t_alu_op          i_op,
    input  wire logic signed [31:0]        i_a,
    input  wire logic signed [31:0]        i_b,
    input  wire logic [ifn_pkg::TS_W-1:0]  i_timestep,
    output logic signed [31:0]             o_y
);

    logic signed [32:0] sum;
    logic signed [32:0] diff;
    logic signed [ifn_pkg::TS_W:0] ts_s;
    logic signed [32+ifn_pkg::TS_W:0] prod;
    logic signed [32+ifn_pkg::TS_W-ifn_pkg::FRAC_W:0] prod_sh;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign sum     = {i_a[31], i_a} + {i_b[31], i_b};
    assign diff    = {i_a[31], i_a} - {i_b[31], i_b};
    assign ts_s    = {1'b0, i_timestep};
    assign prod    = i_a * ts_s;
    // arithmetic shift rounds toward minus infinity
    assign prod_sh = prod[32+ifn_pkg::TS_W:ifn_pkg::FRAC_W];

    always_comb begin
        unique case (i_op)
            ifn_pkg::ALU_ADD: o_y = sat33(sum);
            ifn_pkg::ALU_SUB: o_y = sat33(diff);
            ifn_pkg::ALU_MULSH: begin
                if (prod_sh > 34'sh0_7FFF_FFFF) begin
                    o_y = 32'sh7FFF_FFFF;
                end else if (prod_sh < -34'sh0_8000_0000) begin
                    o_y = 32'sh8000_0000;
                end else begin
                    o_y = prod_sh[31:0];
                end
            end
            default: o_y = i_a;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/ifn_core.sv
// Sequencer and neuron state for the integrate-and-fire array.
// Uses ifn_pkg, ifn_alu and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ifn_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ifn_pkg::t_cfg    i_cfg,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire ifn_pkg::t_item   i_item,
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output ifn_pkg::t_result      o_res
);

    logic signed [31:0] r_membrane [ifn_pkg::NEURONS];
    logic signed [31:0] r_bias     [ifn_pkg::NEURONS];
    logic signed [31:0] r_drive    [ifn_pkg::NEURONS];
    logic [31:0]        r_tally    [ifn_pkg::NEURONS];

    ifn_pkg::t_state r_state, n_state;
    logic [ifn_pkg::IDX_W-1:0] r_i, n_i;
    logic [ifn_pkg::IDX_W-1:0] r_idx, n_idx;
    logic signed [31:0] r_acc, n_acc;

    ifn_pkg::t_alu_op   alu_op;
    logic signed [31:0] alu_a, alu_b, alu_y;

    logic        s_fire;
    logic        fired;
    logic        last_neuron;
    logic        idx_ok;
    logic        item_idx_ok;
    logic [31:0] tally_inc;
    logic signed [31:0] mem_new;

    ifn_alu u_alu (
        .i_op       (alu_op),
        .i_a        (alu_a),
        .i_b        (alu_b),
        .i_timestep (i_cfg.timestep),
        .o_y        (alu_y)
    );

    assign o_ready     = (r_state == ifn_pkg::S_IDLE);
    assign s_fire      = i_valid && o_ready;
    assign last_neuron = (r_i == ifn_pkg::IDX_W'(ifn_pkg::NEURONS - 1));
    assign idx_ok      = (int'(r_idx) < ifn_pkg::NEURONS);
    assign item_idx_ok = (int'(i_item.neuron) < ifn_pkg::NEURONS);
    // in the fire step the unit forms membrane - threshold; positive means spike
    assign fired       = !alu_y[31] && (alu_y != '0);
    assign tally_inc   = (r_tally[r_i] == '1) ? r_tally[r_i] : r_tally[r_i] + 32'd1;
    assign mem_new     = fired ? alu_y : (r_acc[31] ? 32'sd0 : r_acc);

    // operand selection for the shared unit
    always_comb begin
        alu_op = ifn_pkg::ALU_ADD;
        alu_a  = r_acc;
        alu_b  = 32'sd0;
        unique case (r_state)
            ifn_pkg::S_ADD: begin
                alu_a = r_drive[r_i];
                alu_b = r_bias[r_i];
            end
            ifn_pkg::S_MUL: begin
                alu_op = ifn_pkg::ALU_MULSH;
            end
            ifn_pkg::S_MEM: begin
                alu_a = r_membrane[r_i];
                alu_b = r_acc;
            end
            ifn_pkg::S_FIRE: begin
                alu_op = ifn_pkg::ALU_SUB;
                alu_b  = {1'b0, i_cfg.threshold};
            end
            default: ;
        endcase
    end

    // next state and result
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_idx       = r_idx;
        n_acc       = r_acc;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (r_state)
            ifn_pkg::S_IDLE: begin
                if (s_fire) begin
                    n_idx = i_item.neuron;
                    case (i_item.mode)
                        ifn_pkg::MODE_TICK: begin
                            n_i     = '0;
                            n_state = ifn_pkg::S_ADD;
                        end
                        ifn_pkg::MODE_READ: n_state = ifn_pkg::S_READ;
                        default: ;
                    endcase
                end
            end
            ifn_pkg::S_ADD: begin
                n_acc   = alu_y;
                n_state = ifn_pkg::S_MUL;
            end
            ifn_pkg::S_MUL: begin
                n_acc   = alu_y;
                n_state = ifn_pkg::S_MEM;
            end
            ifn_pkg::S_MEM: begin
                n_acc   = alu_y;
                n_state = ifn_pkg::S_FIRE;
            end
            ifn_pkg::S_FIRE: begin
                o_res_valid        = 1'b1;
                o_res.neuron_index = r_i;
                o_res.spiked       = fired;
                o_res.count        = fired ? tally_inc : r_tally[r_i];
                o_res.last         = last_neuron;
                if (i_res_ready) begin
                    n_i     = r_i + 1'b1;
                    n_state = last_neuron ? ifn_pkg::S_IDLE : ifn_pkg::S_ADD;
                end
            end
            ifn_pkg::S_READ: begin
                o_res_valid        = 1'b1;
                o_res.neuron_index = r_idx;
                o_res.spiked       = 1'b0;
                o_res.count        = idx_ok ? r_tally[r_idx] : 32'd0;
                o_res.last         = 1'b1;
                if (i_res_ready) begin
                    n_state = ifn_pkg::S_IDLE;
                end
            end
            default: n_state = ifn_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ifn_pkg::S_IDLE;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_acc <= n_acc;
    end

    // neuron state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ifn_pkg::NEURONS; k++) begin
                r_membrane[k] <= '0;
                r_bias[k]     <= '0;
                r_drive[k]    <= '0;
                r_tally[k]    <= '0;
            end
        end else begin
            if (s_fire) begin
                case (i_item.mode)
                    ifn_pkg::MODE_SET_ONE: begin
                        if (item_idx_ok) begin
                            r_bias[i_item.neuron] <= i_item.current;
                        end
                    end
                    ifn_pkg::MODE_SET_ALL: begin
                        for (int k = 0; k < ifn_pkg::NEURONS; k++) begin
                            r_bias[k] <= i_item.current;
                        end
                    end
                    ifn_pkg::MODE_LOAD: begin
                        if (item_idx_ok) begin
                            r_membrane[i_item.neuron] <= i_item.potential;
                            r_bias[i_item.neuron]     <= i_item.current;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == ifn_pkg::S_MEM) begin
                r_drive[r_i] <= r_acc;
            end
            if (r_state == ifn_pkg::S_FIRE && i_res_ready) begin
                r_membrane[r_i] <= mem_new;
                if (fired) begin
                    r_tally[r_i] <= tally_inc;
                end
            end
        end
    end

    `IFN_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> r_state == ifn_pkg::S_IDLE, "core not idle after reset")
    `IFN_ASSERT(a_tick_start, i_clk, i_rst_n, (s_fire && i_item.mode == ifn_pkg::MODE_TICK) |=> (r_state == ifn_pkg::S_ADD && r_i == '0), "tick did not start at neuron zero")
    `IFN_ASSERT(a_mul_order, i_clk, i_rst_n, (r_state == ifn_pkg::S_MUL) |-> ($past(r_state) == ifn_pkg::S_ADD), "multiply step out of order")
    `IFN_ASSERT(a_mid_result, i_clk, i_rst_n, (o_res_valid && !o_res.last) |-> (r_state == ifn_pkg::S_FIRE), "non-final result outside tick")

endmodule

`default_nettype wire

// File: hdl/integrate_fire_neuron_array_top.sv
// Top level of the integrate-and-fire neuron array: config registers,
// stream ports and output register. Uses ifn_pkg and ifn_core.
`default_nettype none

// Array of NEURONS non-leaky integrate-and-fire neurons, signed Q8.24.
// Input stream (s_axis_*): tuser carries the mode; tdata carries neuron
// index, load potential and current. Mode 0 ticks all neurons, 1 sets one
// bias current, 2 sets all, 3 loads membrane and current, 4 reads a count.
// Output stream (m_axis_*): one item per neuron on a tick (tlast on the
// final neuron) or one item on a count read; set and load give no item.
// Threshold and timestep are written over the plain config port by the user
// only while idle; the block itself does not enforce this. A tick runs four
// steps per neuron through one shared arithmetic unit (add, multiply, add,
// compare/subtract); set and load complete in the idle state, a read in its
// read step. s_axis_tready is high only between items.
// Each result sits in an output register; if m_axis_tready stays low, the
// compare or read step holds and no result is lost or repeated.
// Reset (synchronous, active low) clears all neuron state at once, restores
// the default threshold (0.1) and timestep (~1e-4) and empties the output.
module integrate_fire_neuron_array_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // config write port
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_addr,
    input  wire logic [ifn_pkg::CFG_W-1:0]   i_cfg_wdata,
    // input items
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [4:0] neuron, [36:5] potential, [68:37] current, [71:69] zero
    input  wire logic [71:0]                 s_axis_tdata,
    // [2:0] mode
    input  wire logic [2:0]                  s_axis_tuser,
    // result items
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [4:0] neuron_index, [5] spiked, [37:6] count, [39:38] zero
    output logic [39:0]                      m_axis_tdata,
    output logic                             m_axis_tlast
);

    ifn_pkg::t_cfg    r_cfg;
    ifn_pkg::t_item   item;
    ifn_pkg::t_result res;
    ifn_pkg::t_result r_out;
    logic             r_out_valid;
    logic             res_valid;
    logic             out_free;

    assign item.mode      = s_axis_tuser;
    assign item.neuron    = s_axis_tdata[4:0];
    assign item.potential = s_axis_tdata[36:5];
    assign item.current   = s_axis_tdata[68:37];

    // output register can take a new result when empty or draining
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= ifn_pkg::THRESHOLD_RESET;
            r_cfg.timestep  <= ifn_pkg::TIMESTEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ifn_pkg::CFG_THRESHOLD: r_cfg.threshold <= i_cfg_wdata;
                ifn_pkg::CFG_TIMESTEP:  r_cfg.timestep  <= i_cfg_wdata[ifn_pkg::TS_W-1:0];
                default: ;
            endcase
        end
    end

    ifn_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_item      (item),
        .o_res_valid (res_valid),
        .i_res_ready (out_free),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.count, r_out.spiked, r_out.neuron_index};
    assign m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for integrate_fire_neuron_array_top.
// Drives mode/neuron/potential/current items on the input stream, predicts every
// tick and count-read result in a local neuron-array model, checks the output stream.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ifn_pkg::*;

    // mode codes above MODE_READ are unused by the block and must be ignored
    localparam int MODE_CODE_TOP = 7;
    localparam int INT_TOP       = 32'h7FFF_FFFF;
    localparam int INT_BOTTOM    = 32'h8000_0000;
    localparam logic [31:0] ONE_Q24   = 32'h0100_0000;
    // pause before touching config, long enough for a whole tick
    localparam int SETTLE_CYCLES = 4 * NEURONS + 12;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic                  i_cfg_addr    = CFG_THRESHOLD;
    logic [CFG_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [4:0] neuron, [36:5] potential, [68:37] current, [71:69] zero
    logic [71:0]           s_axis_tdata  = '0;
    // [2:0] mode
    logic [2:0]            s_axis_tuser  = MODE_TICK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [4:0] neuron_index, [5] spiked, [37:6] count, [39:38] zero
    logic [39:0]           m_axis_tdata;
    logic                  m_axis_tlast;

    integrate_fire_neuron_array_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the neuron array and its config.
    // ------------------------------------------------------------------
    int          membrane_q24 [NEURONS];
    int          bias_q24     [NEURONS];
    int          drive_q24    [NEURONS];
    int unsigned fire_tally   [NEURONS];
    int unsigned threshold_now = THRESHOLD_RESET;
    int unsigned timestep_now  = TIMESTEP_RESET;

    t_item   commands_to_send [$];  // items waiting for the driver
    t_result spike_reports_due[$];  // predicted output items, oldest first

    int send_idle_pct = 35;
    int recv_idle_pct = 86;
    int mismatches    = 0;
    int useful_items  = 0;          // items of a defined mode queued this phase

    t_item   seen_cmd;
    t_result seen_report;
    t_result due_report;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(40_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int clip32(longint v);
        if (v > longint'(INT_TOP))
            return INT_TOP;
        if (v < longint'(INT_BOTTOM))
            return INT_BOTTOM;
        return int'(v);
    endfunction

    // One tick: sweep neurons in index order, one report each, tlast on the final one.
    function automatic void integrate_tick();
        int      d;
        int      m;
        logic    fired;
        t_result r;
        for (int i = 0; i < NEURONS; i++) begin
            d = clip32(longint'(drive_q24[i]) + longint'(bias_q24[i]));
            // exact product, >>> on a signed longint floors toward minus infinity
            d = clip32((longint'(d) * longint'(timestep_now)) >>> FRAC_W);
            drive_q24[i] = d;
            m = clip32(longint'(membrane_q24[i]) + longint'(d));
            fired = 1'b0;
            if (longint'(m) > longint'(threshold_now)) begin
                fired = 1'b1;
                m = int'(longint'(m) - longint'(threshold_now));
                if (fire_tally[i] != 32'hFFFF_FFFF)
                    fire_tally[i]++;
            end else if (m < 0) begin
                m = 0;
            end
            membrane_q24[i] = m;
            r.neuron_index = IDX_W'(i);
            r.spiked       = fired;
            r.count        = fire_tally[i];
            r.last         = (i == NEURONS - 1);
            spike_reports_due.push_back(r);
        end
    endfunction

    function automatic void apply_command(t_item c);
        t_result r;
        case (c.mode)
            MODE_TICK: integrate_tick();
            MODE_SET_ONE: begin
                if (c.neuron < NEURONS)
                    bias_q24[c.neuron] = c.current;
            end
            MODE_SET_ALL: begin
                foreach (bias_q24[i])
                    bias_q24[i] = c.current;
            end
            MODE_LOAD: begin
                // drive and spike count are kept
                if (c.neuron < NEURONS) begin
                    membrane_q24[c.neuron] = c.potential;
                    bias_q24[c.neuron]     = c.current;
                end
            end
            MODE_READ: begin
                r.neuron_index = c.neuron;
                r.spiked       = 1'b0;
                r.count        = (c.neuron < NEURONS) ? fire_tally[c.neuron] : '0;
                r.last         = 1'b1;
                spike_reports_due.push_back(r);
            end
            default: ;  // unused modes: no effect, no output
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued items, idles at random between them.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (commands_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= commands_to_send[0].mode;
                s_axis_tdata  <= {3'b000, commands_to_send[0].current,
                                  commands_to_send[0].potential, commands_to_send[0].neuron};
                commands_to_send.delete(0);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: check outputs against the oldest prediction, then predict
    // whatever was accepted on the input side at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_report.neuron_index = m_axis_tdata[4:0];
            seen_report.spiked       = m_axis_tdata[5];
            seen_report.count        = m_axis_tdata[37:6];
            seen_report.last         = m_axis_tlast;
            if (spike_reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected output item idx=%0d spiked=%0b count=%0d last=%0b",
                             $realtime, seen_report.neuron_index, seen_report.spiked,
                             seen_report.count, seen_report.last);
            end else begin
                due_report = spike_reports_due.pop_front();
                if (seen_report.neuron_index !== due_report.neuron_index ||
                    seen_report.spiked !== due_report.spiked ||
                    seen_report.count !== due_report.count ||
                    seen_report.last !== due_report.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: mismatch exp idx=%0d spiked=%0b count=%0d last=%0b",
                                  " / got idx=%0d spiked=%0b count=%0d last=%0b"},
                                 $realtime, due_report.neuron_index, due_report.spiked,
                                 due_report.count, due_report.last,
                                 seen_report.neuron_index, seen_report.spiked,
                                 seen_report.count, seen_report.last);
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            seen_cmd.mode      = s_axis_tuser;
            seen_cmd.neuron    = s_axis_tdata[4:0];
            seen_cmd.potential = s_axis_tdata[36:5];
            seen_cmd.current   = s_axis_tdata[68:37];
            apply_command(seen_cmd);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_cmd(logic [2:0] mode, logic [IDX_W-1:0] neuron,
                             logic [31:0] potential, logic [31:0] current);
        t_item c;
        c.mode      = mode;
        c.neuron    = neuron;
        c.potential = potential;
        c.current   = current;
        commands_to_send.push_back(c);
        if (mode <= MODE_READ)
            useful_items++;
    endtask

    // Q8.24 value: mostly moderate magnitudes so spikes come and go, some full range
    function automatic logic [31:0] pick_q24();
        logic [31:0] mag;
        case ($urandom_range(4))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: begin
                mag = $urandom_range(0, 32'h0200_0000);
                return $urandom_range(1) ? mag : -mag;
            end
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_neuron();
        return IDX_W'($urandom_range(NEURONS - 1));
    endfunction

    // A well-formed run: set up currents/membranes, tick a few times, read back.
    // One in six runs is plain noise (any mode, any fields).
    task automatic queue_run();
        int n;
        if ($urandom_range(5) == 0) begin
            queue_cmd(3'($urandom_range(MODE_CODE_TOP)), pick_neuron(), $urandom, $urandom);
            return;
        end
        n = $urandom_range(1, 4);
        repeat (n) begin
            case ($urandom_range(2))
                0: queue_cmd(MODE_SET_ONE, pick_neuron(), $urandom, pick_q24());
                1: queue_cmd(MODE_SET_ALL, pick_neuron(), $urandom, pick_q24());
                default: queue_cmd(MODE_LOAD, pick_neuron(), pick_q24(), pick_q24());
            endcase
        end
        n = $urandom_range(1, 3);
        repeat (n) queue_cmd(MODE_TICK, pick_neuron(), $urandom, $urandom);
        n = $urandom_range(0, 2);
        repeat (n) queue_cmd(MODE_READ, pick_neuron(), $urandom, $urandom);
    endtask

    // Block is idle once everything is sent and answered; set/load leave no
    // trace on the output, so allow a full tick's worth of cycles on top.
    // Sampled on the falling edge so the driver and monitor updates have settled.
    task automatic wait_idle();
        while (commands_to_send.size() != 0 || s_axis_tvalid || spike_reports_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic addr, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        if (addr == CFG_THRESHOLD)
            threshold_now = value[THR_W-1:0];
        else
            timestep_now = value[TS_W-1:0];
    endtask

    task automatic run_phase(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] ts,
                             int send_pct, int recv_pct, int n_items);
        wait_idle();
        write_register(CFG_THRESHOLD, thr);
        write_register(CFG_TIMESTEP, ts);
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        useful_items  = 0;
        while (useful_items < n_items)
            queue_run();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset threshold and timestep.
        queue_cmd(MODE_READ, 5'd0, '0, '0);                      // count is zero after reset
        queue_cmd(MODE_TICK, '0, '0, '0);                        // all-zero state, no spikes
        queue_cmd(MODE_SET_ONE, 5'd0, '0, 32'h7FFF_FFFF);        // largest current
        queue_cmd(MODE_SET_ONE, 5'd31, '1, 32'h8000_0000);       // most negative current
        queue_cmd(MODE_LOAD, 5'd5, 32'h7FFF_FFFF, '0);           // full membrane fires at once
        queue_cmd(MODE_LOAD, 5'd6, 32'h8000_0000, 32'h8000_0000);// clamps to zero
        queue_cmd(MODE_LOAD, 5'd30, 32'hFFFF_FFFF, 32'h0000_0001);
        queue_cmd(MODE_READ + 3'd1, 5'd7, $urandom, $urandom);   // unused modes do nothing
        queue_cmd(MODE_READ + 3'd2, 5'd8, $urandom, $urandom);
        queue_cmd(3'(MODE_CODE_TOP), 5'd31, '1, '1);
        queue_cmd(MODE_TICK, '1, '1, '1);
        queue_cmd(MODE_TICK, '0, '0, '0);
        queue_cmd(MODE_READ, 5'd5, '0, '0);
        queue_cmd(MODE_READ, 5'd31, '1, '1);
        queue_cmd(MODE_SET_ALL, 5'd3, '0, ONE_Q24);
        queue_cmd(MODE_LOAD, 5'd5, 32'h0000_1000, 32'hFF00_0000); // load keeps drive and count
        queue_cmd(MODE_TICK, '0, '0, '0);
        queue_cmd(MODE_READ, 5'd5, '0, '0);
        queue_cmd(MODE_SET_ALL, '0, '0, '0);
        queue_cmd(MODE_TICK, '0, '0, '0);

        // Random phases; sender-light/receiver-heavy idling first, then swapped for two phases, then none.
        // zero threshold, unit timestep: every positive membrane fires
        run_phase(CFG_W'(0), CFG_W'(ONE_Q24), 35, 86, 90);
        // top threshold, zero timestep: drive collapses, nothing can fire
        run_phase(CFG_W'(INT_TOP), CFG_W'(0), 86, 35, 60);
        run_phase(CFG_W'(ONE_Q24), CFG_W'(ONE_Q24), 86, 35, 90);
        run_phase(CFG_W'($urandom_range(0, 32'h1000_0000)),
                  CFG_W'($urandom_range(32'h0040_0000, ONE_Q24)), 0, 0, 100);

        wait_idle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/ifn_pkg.sv
hdl/ifn_alu.sv
hdl/ifn_core.sv
hdl/integrate_fire_neuron_array_top.sv
tb/tb_top.sv
